>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL in this folder.
// Needs nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/cfpa_pkg.sv
// Package for the complex fixed-point ALU: widths, opcodes, pipeline depth.
// No dependencies.
package cfpa_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;
  localparam int PW  = 2 * DATA_WIDTH;       // one product
  localparam int SW  = PW + 1;               // sum of two product magnitudes
  localparam int NW  = SW + FRAC_BITS;       // scaled numerator
  localparam int QW  = NW;                   // quotient width
  localparam int DIV_STAGES  = NW;           // one quotient bit per stage
  localparam int SQRT_STAGES = (SW + 1) / 2; // one root bit per stage
  localparam int LAT = 3 + DIV_STAGES + 1;   // start to strobe

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4
  } op_t;
endpackage

>>> rtl/core/complex_fixed_point_alu.sv
// Top level of the complex fixed-point ALU: fully pipelined datapath.
// Depends on cfpa_pkg and assert_macros.svh.
//
// Usage:
//  - A request is taken at a rising edge with start high and busy low. busy
//    is tied low: a new request may enter every cycle.
//  - Each request gives opcode and two Q8.8 complex operands a, b.
//  - Exactly one result per request: out_valid comes from the output register
//    after the three front stages and the divider stages (as sized at Q8.8);
//    results stay in request order.
//  - Latency is set by the restoring divider, one quotient bit per stage
//    (41 stages); the square root runs beside it in fewer stages and is
//    delayed to match. Add, subtract and multiply ride the same delay line.
//  - Throughput: one request per cycle, sustained.
//  - The receiver cannot stall; out_ ports carry the result only in the
//    strobe cycle and must be taken then.
//  - Reset (rst_n low, synchronous) clears all valid bits; requests in flight
//    are dropped. Data registers are not reset.
//  - Unused opcodes return zero with both flags low.
//  - Divide by zero returns zero with div_zero set.
`include "assert_macros.svh"
module complex_fixed_point_alu
  import cfpa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_res_re,
  output logic signed [DATA_WIDTH-1:0] out_res_im,
  output logic                         out_overflow,
  output logic                         out_div_zero
);
  localparam int DW = DATA_WIDTH;
  localparam logic [SW-1:0] POS_MAX = SW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [SW-1:0] NEG_MAX = SW'(64'd1 << (DW - 1));

  assign busy = 1'b0;

  // ---------------- stage 1: register inputs ----------------
  logic              v1_r;
  logic [2:0]        op1_r;
  logic signed [DW-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    op1_r <= in_opcode;
    ar1_r <= in_a_re;
    ai1_r <= in_a_im;
    br1_r <= in_b_re;
    bi1_r <= in_b_im;
  end

  // ---------------- stage 2: products and add/sub sums ----------------
  // six products cover mul, div and mag; the first two pick operands by opcode
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb1_r, p_bb2_r;
  logic signed [DW:0]   sum_re_r, sum_im_r;
  logic              v2_r;
  logic [2:0]        op2_r;
  logic signed [DW-1:0] m1a, m1b, m2a, m2b;

  always_comb begin
    m1a = ar1_r; m1b = br1_r; m2a = ai1_r; m2b = bi1_r;
    if (op1_r == OP_MAG) begin
      m1b = ar1_r;
      m2b = ai1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    op2_r   <= op1_r;
    p_rr_r  <= m1a * m1b;
    p_ii_r  <= m2a * m2b;
    p_ri_r  <= ar1_r * bi1_r;
    p_ir_r  <= ai1_r * br1_r;
    p_bb1_r <= br1_r * br1_r;
    p_bb2_r <= bi1_r * bi1_r;
    if (op1_r == OP_SUB) begin
      sum_re_r <= (DW+1)'(ar1_r) - (DW+1)'(br1_r);
      sum_im_r <= (DW+1)'(ai1_r) - (DW+1)'(bi1_r);
    end else begin
      sum_re_r <= (DW+1)'(ar1_r) + (DW+1)'(br1_r);
      sum_im_r <= (DW+1)'(ai1_r) + (DW+1)'(bi1_r);
    end
  end

  // ---------------- stage 3: sums of products ----------------
  logic signed [SW-1:0] x_re_r, x_im_r;   // signed combined values
  logic [SW-1:0]        den_r;
  logic                 v3_r;
  logic [2:0]           op3_r;
  logic signed [DW:0]   s3_re_r, s3_im_r;
  logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir;

  always_comb begin
    e_rr = SW'(p_rr_r);
    e_ii = SW'(p_ii_r);
    e_ri = SW'(p_ri_r);
    e_ir = SW'(p_ir_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    op3_r   <= op2_r;
    s3_re_r <= sum_re_r;
    s3_im_r <= sum_im_r;
    den_r   <= SW'($unsigned(p_bb1_r)) + SW'($unsigned(p_bb2_r));
    case (op2_r)
      OP_MUL: begin
        x_re_r <= e_rr - e_ii;
        x_im_r <= e_ri + e_ir;
      end
      OP_DIV: begin
        x_re_r <= e_rr + e_ii;
        x_im_r <= e_ir - e_ri;
      end
      default: begin
        x_re_r <= e_rr + e_ii;   // magnitude squared for OP_MAG
        x_im_r <= '0;
      end
    endcase
  end

  // ---------------- divider and sqrt lanes ----------------
  // restoring divider: one quotient bit per stage, two lanes
  logic [NW-1:0] dn_re_r [DIV_STAGES+1];
  logic [NW-1:0] dn_im_r [DIV_STAGES+1];
  logic [SW:0]   dr_re_r [DIV_STAGES+1];
  logic [SW:0]   dr_im_r [DIV_STAGES+1];
  logic [SW-1:0] dd_r    [DIV_STAGES+1];
  logic          dv_r    [DIV_STAGES+1];
  logic [2:0]    dop_r   [DIV_STAGES+1];
  logic          nre_r   [DIV_STAGES+1];
  logic          nim_r   [DIV_STAGES+1];
  logic signed [DW:0] ds_re_r [DIV_STAGES+1];
  logic signed [DW:0] ds_im_r [DIV_STAGES+1];
  logic signed [SW-1:0] dx_re_r [DIV_STAGES+1];
  logic signed [SW-1:0] dx_im_r [DIV_STAGES+1];
  // sqrt state: remainder n and result res; the bit index is fixed per stage
  logic [SW-1:0]  sq_n_r   [DIV_STAGES+1];
  logic [SW-1:0]  sq_res_r [DIV_STAGES+1];

  logic [SW-1:0] abs_re, abs_im;
  always_comb begin
    abs_re = x_re_r[SW-1] ? SW'(-x_re_r) : SW'(x_re_r);
    abs_im = x_im_r[SW-1] ? SW'(-x_im_r) : SW'(x_im_r);
  end

  always_comb begin
    dn_re_r[0]  = {abs_re, {FRAC_BITS{1'b0}}};
    dn_im_r[0]  = {abs_im, {FRAC_BITS{1'b0}}};
    dr_re_r[0]  = '0;
    dr_im_r[0]  = '0;
    dd_r[0]     = den_r;
    dv_r[0]     = v3_r;
    dop_r[0]    = op3_r;
    nre_r[0]    = x_re_r[SW-1];
    nim_r[0]    = x_im_r[SW-1];
    ds_re_r[0]  = s3_re_r;
    ds_im_r[0]  = s3_im_r;
    dx_re_r[0]  = x_re_r;
    dx_im_r[0]  = x_im_r;
    sq_n_r[0]   = x_re_r;
    sq_res_r[0] = '0;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    // sqrt bit position; stages past the root only carry it along
    localparam int SB = (g < SQRT_STAGES) ? 2 * (SQRT_STAGES - 1 - g) : 0;
    logic [SW:0] t_re, t_im;
    logic [SW+1:0] sq_try;
    logic [SW-1:0] sq_n_nxt, sq_res_nxt;
    always_comb begin
      t_re = {dr_re_r[g][SW-1:0], dn_re_r[g][NW-1]};
      t_im = {dr_im_r[g][SW-1:0], dn_im_r[g][NW-1]};
      sq_n_nxt   = sq_n_r[g];
      sq_res_nxt = sq_res_r[g];
      sq_try     = '0;
      if (g < SQRT_STAGES) begin
        sq_try = (SW+2)'(sq_res_r[g]) + ((SW+2)'(1) << SB);
        if ((SW+2)'(sq_n_r[g]) >= sq_try) begin
          sq_n_nxt   = SW'((SW+2)'(sq_n_r[g]) - sq_try);
          sq_res_nxt = SW'(((SW+2)'(sq_res_r[g]) >> 1) + ((SW+2)'(1) << SB));
        end else begin
          sq_res_nxt = sq_res_r[g] >> 1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[g+1] <= 1'b0;
      else        dv_r[g+1] <= dv_r[g];
      if (t_re >= {1'b0, dd_r[g]}) begin
        dr_re_r[g+1] <= t_re - {1'b0, dd_r[g]};
        dn_re_r[g+1] <= {dn_re_r[g][NW-2:0], 1'b1};
      end else begin
        dr_re_r[g+1] <= t_re;
        dn_re_r[g+1] <= {dn_re_r[g][NW-2:0], 1'b0};
      end
      if (t_im >= {1'b0, dd_r[g]}) begin
        dr_im_r[g+1] <= t_im - {1'b0, dd_r[g]};
        dn_im_r[g+1] <= {dn_im_r[g][NW-2:0], 1'b1};
      end else begin
        dr_im_r[g+1] <= t_im;
        dn_im_r[g+1] <= {dn_im_r[g][NW-2:0], 1'b0};
      end
      dd_r[g+1]     <= dd_r[g];
      dop_r[g+1]    <= dop_r[g];
      nre_r[g+1]    <= nre_r[g];
      nim_r[g+1]    <= nim_r[g];
      ds_re_r[g+1]  <= ds_re_r[g];
      ds_im_r[g+1]  <= ds_im_r[g];
      dx_re_r[g+1]  <= dx_re_r[g];
      dx_im_r[g+1]  <= dx_im_r[g];
      sq_n_r[g+1]   <= sq_n_nxt;
      sq_res_r[g+1] <= sq_res_nxt;
    end
  end

  // ---------------- final stage: select, floor, saturate ----------------
  localparam int L = DIV_STAGES;

  function automatic logic [DW:0] sat_sm(input logic neg, input logic [QW-1:0] mag);
    // returns {ovf, value}
    logic [DW:0] r;
    if (neg) begin
      if (mag > QW'(NEG_MAX)) r = {1'b1, DW'(NEG_MAX)};
      else                    r = {1'b0, DW'(-mag)};
    end else begin
      if (mag > QW'(POS_MAX)) r = {1'b1, DW'(POS_MAX)};
      else                    r = {1'b0, DW'(mag)};
    end
    return r;
  endfunction

  // floor shift of a signed value then saturate
  function automatic logic [DW:0] sat_floor(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] s;
    logic [DW:0] r;
    s = x >>> FRAC_BITS;
    if (s > $signed(POS_MAX))      r = {1'b1, DW'(POS_MAX)};
    else if (s < -$signed(NEG_MAX)) r = {1'b1, DW'(NEG_MAX)};
    else                            r = {1'b0, DW'(s)};
    return r;
  endfunction

  function automatic logic [DW:0] sat_add(input logic signed [DW:0] x);
    logic [DW:0] r;
    if (x[DW] != x[DW-1]) r = {1'b1, x[DW] ? DW'(NEG_MAX) : DW'(POS_MAX)};
    else                  r = {1'b0, DW'(x)};
    return r;
  endfunction

  logic [DW:0] f_re, f_im;
  logic        f_dz;
  logic        dz_lane;
  always_comb begin
    f_re = '0;
    f_im = '0;
    f_dz = 1'b0;
    dz_lane = (dd_r[L] == '0);
    case (dop_r[L])
      OP_ADD, OP_SUB: begin
        f_re = sat_add(ds_re_r[L]);
        f_im = sat_add(ds_im_r[L]);
      end
      OP_MUL: begin
        f_re = sat_floor(dx_re_r[L]);
        f_im = sat_floor(dx_im_r[L]);
      end
      OP_DIV: begin
        if (dz_lane) f_dz = 1'b1;
        else begin
          f_re = sat_sm(nre_r[L], dn_re_r[L]);
          f_im = sat_sm(nim_r[L], dn_im_r[L]);
        end
      end
      OP_MAG: begin
        f_re = sat_sm(1'b0, QW'(sq_res_r[L]));
      end
      default: ;
    endcase
  end

  logic out_valid_r, out_ovf_r, out_dz_r;
  logic signed [DW-1:0] out_re_r, out_im_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_r[L];
    out_re_r  <= f_re[DW-1:0];
    out_im_r  <= f_im[DW-1:0];
    out_ovf_r <= f_re[DW] | f_im[DW];
    out_dz_r  <= f_dz;
  end

  assign out_valid    = out_valid_r;
  assign out_res_re   = out_re_r;
  assign out_res_im   = out_im_r;
  assign out_overflow = out_ovf_r;
  assign out_div_zero = out_dz_r;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_dz_clean, clk, rst_n, out_valid && out_div_zero,
    !out_overflow && out_res_re == '0 && out_res_im == '0)
  `ASSERT_NEXT(a_valid_flow, clk, rst_n, dv_r[L], out_valid)
  `ASSERT_IMPL(a_mag_im, clk, rst_n, dv_r[L] && dop_r[L] == OP_MAG, f_im == '0)
endmodule

>>> dv/cfpa_checker.sv
// Result checker for the complex fixed-point ALU: predicts each request's result
// and compares it with the strobed output. Depends on cfpa_pkg.
module cfpa_checker
  import cfpa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [2:0]                   in_opcode,
  input  logic signed [DATA_WIDTH-1:0] in_a_re,
  input  logic signed [DATA_WIDTH-1:0] in_a_im,
  input  logic signed [DATA_WIDTH-1:0] in_b_re,
  input  logic signed [DATA_WIDTH-1:0] in_b_im,
  input  logic                         out_valid,
  input  logic signed [DATA_WIDTH-1:0] out_res_re,
  input  logic signed [DATA_WIDTH-1:0] out_res_im,
  input  logic                         out_overflow,
  input  logic                         out_div_zero,
  output int                           fail_count,
  output int                           pending
);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] re;
    logic signed [DATA_WIDTH-1:0] im;
    logic                         ovf;
    logic                         dz;
  } cplx_res_t;

  cplx_res_t expected_results[$];

  localparam longint MAXV = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint MINV = -(longint'(1) <<< (DATA_WIDTH - 1));

  // clamp to the signed output range, flag on clip
  function automatic logic [DATA_WIDTH-1:0] clamp(input longint v, inout logic ovf);
    if (v > MAXV) begin
      ovf = 1'b1;
      return MAXV[DATA_WIDTH-1:0];
    end
    if (v < MINV) begin
      ovf = 1'b1;
      return MINV[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // fixed-point quotient (n << FRAC_BITS) / d, toward zero
  function automatic longint scaled_quot(input longint n, input longint d);
    longint m;
    m = (n < 0) ? -n : n;
    m = (m <<< FRAC_BITS) / d;
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint floor_sqrt(input longint n);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if ((r + (longint'(1) <<< b)) * (r + (longint'(1) <<< b)) <= n)
        r = r + (longint'(1) <<< b);
    return r;
  endfunction

  function automatic cplx_res_t compute_result(input logic [2:0] op, input longint ar,
                                               input longint ai, input longint br,
                                               input longint bi);
    cplx_res_t r;
    longint den;
    r = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp(ar + br, r.ovf);
        r.im = clamp(ai + bi, r.ovf);
      end
      OP_SUB: begin
        r.re = clamp(ar - br, r.ovf);
        r.im = clamp(ai - bi, r.ovf);
      end
      OP_MUL: begin
        // arithmetic shift floors
        r.re = clamp((ar * br - ai * bi) >>> FRAC_BITS, r.ovf);
        r.im = clamp((ar * bi + ai * br) >>> FRAC_BITS, r.ovf);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.dz = 1'b1;
        else begin
          r.re = clamp(scaled_quot(ar * br + ai * bi, den), r.ovf);
          r.im = clamp(scaled_quot(ai * br - ar * bi, den), r.ovf);
        end
      end
      OP_MAG: r.re = clamp(floor_sqrt(ar * ar + ai * ai), r.ovf);
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_results.size();

  initial fail_count = 0;

  // predict on accepted requests, compare strobed results
  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request outstanding", $realtime);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_res_re !== want.re) report_mismatch("res_re", out_res_re, want.re);
        if (out_res_im !== want.im) report_mismatch("res_im", out_res_im, want.im);
        if (out_overflow !== want.ovf) report_mismatch("overflow", out_overflow, want.ovf);
        if (out_div_zero !== want.dz) report_mismatch("div_zero", out_div_zero, want.dz);
      end
    end
    if (rst_n && start && !busy)
      expected_results.push_back(compute_result(in_opcode, in_a_re, in_a_im,
                                                in_b_re, in_b_im));
  end

endmodule

>>> dv/tb_complex_fixed_point_alu.sv
// Testbench top for the complex fixed-point ALU: drives directed and random
// requests in bursts. Depends on cfpa_pkg, the ALU and cfpa_checker.
module tb_complex_fixed_point_alu;
  import cfpa_pkg::*;

  localparam int NUM_RANDOM = 1800;
  localparam int IDLE_LIMIT = 4 * LAT + 2000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [2:0]                   in_opcode = '0;
  logic signed [DATA_WIDTH-1:0] in_a_re = '0;
  logic signed [DATA_WIDTH-1:0] in_a_im = '0;
  logic signed [DATA_WIDTH-1:0] in_b_re = '0;
  logic signed [DATA_WIDTH-1:0] in_b_im = '0;
  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_res_re;
  logic signed [DATA_WIDTH-1:0] out_res_im;
  logic                         out_overflow;
  logic                         out_div_zero;
  int                           fail_count;
  int                           pending;
  int                           idle_cycles = 0;

  localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  always #4 clk = ~clk;

  complex_fixed_point_alu dut (.*);

  cfpa_checker u_checker (.*);

  // watchdog: cycles without an accepted request or result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one request, held until taken
  task automatic send_request(input logic [2:0] op, input logic [DATA_WIDTH-1:0] ar,
                              input logic [DATA_WIDTH-1:0] ai,
                              input logic [DATA_WIDTH-1:0] br,
                              input logic [DATA_WIDTH-1:0] bi);
    start     <= 1'b1;
    in_opcode <= op;
    in_a_re   <= ar;
    in_a_im   <= ai;
    in_b_re   <= br;
    in_b_im   <= bi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic go_idle(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // operand with a bias toward edge values
  function automatic logic [DATA_WIDTH-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2: return '0;
      3: return DATA_WIDTH'($urandom_range(0, 1024)) - DATA_WIDTH'(512);
      default: return DATA_WIDTH'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every opcode at the extremes, divide by zero, unused codes
    send_request(OP_ADD, VMAX, VMIN, VMAX, VMIN);
    send_request(OP_SUB, VMIN, VMAX, VMAX, VMIN);
    send_request(OP_MUL, VMIN, VMIN, VMIN, VMIN);
    send_request(OP_MUL, VMAX, VMIN, VMIN, VMAX);
    send_request(OP_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0000);
    send_request(OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    send_request(OP_DIV, VMAX, VMAX, 16'h0001, 16'h0000);
    send_request(OP_DIV, VMIN, VMIN, VMIN, VMIN);
    send_request(OP_DIV, 16'hff00, 16'h0100, 16'h0300, 16'h0000);
    send_request(OP_MAG, VMIN, VMIN, '0, '0);
    send_request(OP_MAG, 16'h0300, 16'h0400, '0, '0);
    send_request(OP_MAG, '0, '0, VMAX, VMAX);
    send_request(3'd5, VMAX, VMAX, VMAX, VMAX);
    send_request(3'd6, VMIN, 16'h1234, 16'h5678, 16'h9abc);
    send_request(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_request(OP_ADD, '0, '0, '0, '0);

    // hold off until the pipeline drains
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    // random bursts with random gaps
    for (int i = 0; i < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < NUM_RANDOM; k++, i++)
        send_request(($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4)),
                     rand_operand(), rand_operand(), rand_operand(), rand_operand());
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 50));
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> complex_fixed_point_alu.f
+incdir+rtl/core
rtl/core/cfpa_pkg.sv
rtl/core/complex_fixed_point_alu.sv
dv/cfpa_checker.sv
dv/tb_complex_fixed_point_alu.sv
